FILE: src/quantize_and_hash_ingest_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for quantize_and_hash_ingest
// Shared property forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUANTIZE_AND_HASH_INGEST_DEFINES_SVH
`define QUANTIZE_AND_HASH_INGEST_DEFINES_SVH

// same-cycle implication
`define QHI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qhi assertion failed");

// next-cycle implication
`define QHI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qhi assertion failed");

`endif

FILE: src/qhi_pkg.sv
// ----------------------------------------------------------------------------
// qhi_pkg
// Types, constants and the FNV-1a fold shared by the ingest block.
// ----------------------------------------------------------------------------
package qhi_pkg;

  localparam int SAMPLE_W = 32;
  localparam int LEN_W    = 17;
  localparam int CAP_W    = 17;
  localparam int BUDGET_W = 16;
  localparam int ENERGY_W = 32;
  localparam int HASH_W   = 64;
  localparam int CFG_W    = 17;
  localparam int PROD_W   = 38;
  localparam int RND_W    = 39;

  localparam int HASH_STEPS = 4;
  localparam int STEP_W     = 2;

  localparam logic [HASH_W-1:0]   FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HASH_W-1:0]   FNV_PRIME_LO = 64'h0000_0000_0000_01B3;
  localparam logic [CAP_W-1:0]    CAP_RESET    = 17'd12504;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd3100;
  localparam logic [ENERGY_W-1:0] ENERGY_RESET = 32'd180;
  localparam logic [PROD_W-1:0]   SCALE        = 38'd10000;
  localparam logic [7:0]          EXP_UNITY    = 8'd150;
  localparam logic [7:0]          EXP_SPECIAL  = 8'hFF;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_BUDGET   = 1'b1;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_OVER_BUDGET = 2'd1;
  localparam logic [1:0] STATUS_REJECT      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_HASH,
    ST_ELEM_END,
    ST_EMIT
  } qhi_state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic hash_step;
    logic finish;
    logic emit;
  } qhi_cmd_t;

  typedef struct packed {
    logic zero_len;
    logic reject;
    logic hash_last;
    logic more;
    logic out_free;
  } qhi_sts_t;

  // one FNV-1a byte fold: prime is 2^40 + 0x1B3
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x * FNV_PRIME_LO);
  endfunction

endpackage

FILE: src/qhi_ctrl.sv
// ----------------------------------------------------------------------------
// qhi_ctrl
// Sequencer: start check, hash fold steps, element end, result hand-off.
// ----------------------------------------------------------------------------
module qhi_ctrl import qhi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qhi_sts_t sts,
  output qhi_cmd_t cmd
);

  qhi_state_t state_r;
  qhi_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        if (sts.zero_len) state_nxt = ST_EMIT;
        else if (sts.reject) state_nxt = ST_ELEM_END;
        else state_nxt = ST_HASH;
      end
      ST_HASH: begin
        if (sts.hash_last) state_nxt = ST_ELEM_END;
      end
      ST_ELEM_END: begin
        state_nxt = sts.more ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold the input off outside idle and while reset is asserted; decode the state into commands
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = !rst_n;
        cmd.accept = in_valid && rst_n;
      end
      ST_START:    cmd.start     = 1'b1;
      ST_HASH:     cmd.hash_step = 1'b1;
      ST_ELEM_END: cmd.finish    = 1'b1;
      ST_EMIT:     cmd.emit      = sts.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

FILE: src/qhi_datapath.sv
// ----------------------------------------------------------------------------
// qhi_datapath
// Config registers, scaling pipe, FNV-1a fold unit, ingest state, output word.
// ----------------------------------------------------------------------------
module qhi_datapath import qhi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic [SAMPLE_W-1:0] in_sample_bits,
  input  logic [LEN_W-1:0]    in_vector_length,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [HASH_W-1:0]   out_root_hash,
  output logic [LEN_W-1:0]    out_stored_total,
  input  qhi_cmd_t            cmd,
  output qhi_sts_t            sts
);

  logic [CAP_W-1:0]    cap_r;
  logic [BUDGET_W-1:0] budget_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    stored_r;
  logic [HASH_W-1:0]   hash_r;
  logic [ENERGY_W-1:0] energy_r;
  logic [LEN_W-1:0]    pos_r;
  logic                rejected_r;
  logic [LEN_W-1:0]    cur_len_r;
  logic [1:0]          res_status_r;
  logic [STEP_W-1:0]   step_r;
  logic [PROD_W-1:0]   prod_r;
  logic [RND_W-1:0]    rnd_r;
  logic [31:0]         scaled_r;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [HASH_W-1:0]   out_hash_r;
  logic [LEN_W-1:0]    out_stored_r;

  logic [PROD_W-1:0]   prod_nxt;
  logic [RND_W-1:0]    rnd_nxt;
  logic [31:0]         scaled_nxt;
  logic [HASH_W-1:0]   hash_nxt;
  logic [ENERGY_W-1:0] energy_nxt;
  logic [1:0]          final_status;
  logic [7:0]          exp_bits;
  logic [23:0]         signif;
  logic [24:0]         q_rnd;
  logic                rnd_up;
  logic [7:0]          shamt;
  logic [RND_W-1:0]    shifted;
  logic [ENERGY_W:0]   energy_sum;
  logic                first;
  logic                over_cap;
  logic [15:0]         rec_idx;
  logic [31:0]         mag;
  logic [7:0]          b0, b1, b2;

  assign exp_bits = sample_r[30:23];
  assign signif   = {exp_bits != 8'd0, sample_r[22:0]};
  assign prod_nxt = PROD_W'(signif) * SCALE;

  // round product to 24 significant bits, nearest even
  always_comb begin
    if (prod_r[37]) begin
      rnd_up  = prod_r[13] && ((|prod_r[12:0]) || prod_r[14]);
      q_rnd   = {1'b0, prod_r[37:14]} + 25'(rnd_up);
      rnd_nxt = {q_rnd, 14'd0};
    end else begin
      rnd_up  = prod_r[12] && ((|prod_r[11:0]) || prod_r[13]);
      q_rnd   = {1'b0, prod_r[36:13]} + 25'(rnd_up);
      rnd_nxt = {1'b0, q_rnd, 13'd0};
    end
  end

  // scale back by the exponent, saturating large values and flushing small ones to zero
  always_comb begin
    shamt      = EXP_UNITY - exp_bits;
    shifted    = rnd_r >> shamt[5:0];
    scaled_nxt = shifted[31:0];
    if (exp_bits == EXP_SPECIAL || exp_bits >= EXP_UNITY) begin
      scaled_nxt = '1;
    end else if (exp_bits == 8'd0 || shamt >= 8'(RND_W)) begin
      scaled_nxt = '0;
    end else if (|shifted[RND_W-1:32]) begin
      scaled_nxt = '1;
    end
  end

  assign rec_idx = stored_r[15:0] + pos_r[15:0];
  assign mag     = {1'b0, sample_r[30:0]};

  always_comb begin
    case (step_r)
      2'd0:    {b2, b1, b0} = {8'd0, rec_idx[15:8], rec_idx[7:0]};
      2'd1:    {b2, b1, b0} = {mag[15:8], mag[7:0], 8'd0};
      2'd2:    {b2, b1, b0} = {scaled_r[7:0], mag[31:24], mag[23:16]};
      default: {b2, b1, b0} = {scaled_r[31:24], scaled_r[23:16], scaled_r[15:8]};
    endcase
    hash_nxt = fnv_fold(fnv_fold(fnv_fold(hash_r, b0), b1), b2);
  end

  assign first    = pos_r == '0;
  assign over_cap = ({1'b0, stored_r} + {1'b0, len_r}) > {1'b0, cap_r};

  assign energy_sum   = {1'b0, energy_r} + (ENERGY_W + 1)'({cur_len_r, 1'b0});
  assign energy_nxt   = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
  assign final_status = (energy_nxt <= ENERGY_W'(budget_r)) ? STATUS_OK : STATUS_OVER_BUDGET;

  assign sts.zero_len  = first && (len_r == '0);
  assign sts.reject    = first ? over_cap : rejected_r;
  assign sts.hash_last = step_r == STEP_W'(HASH_STEPS - 1);
  assign sts.more      = ({1'b0, pos_r} + (LEN_W + 1)'(1)) < {1'b0, cur_len_r};
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      budget_r <= BUDGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_r    <= cfg_wdata[CAP_W-1:0];
        CFG_BUDGET:   budget_r <= cfg_wdata[BUDGET_W-1:0];
        default:      cap_r    <= cap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    rnd_r    <= rnd_nxt;
    scaled_r <= scaled_nxt;
    if (cmd.accept) begin
      sample_r <= in_sample_bits;
      len_r    <= in_vector_length;
    end
    if (cmd.start && sts.zero_len) res_status_r <= STATUS_REJECT;
    if (cmd.finish && !sts.more) res_status_r <= rejected_r ? STATUS_REJECT : final_status;
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_hash_r   <= hash_r;
      out_stored_r <= stored_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r    <= '0;
      hash_r      <= FNV_BASIS;
      energy_r    <= ENERGY_RESET;
      pos_r       <= '0;
      rejected_r  <= 1'b0;
      cur_len_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        step_r <= '0;
        if (first && len_r != '0) begin
          cur_len_r  <= len_r;
          rejected_r <= over_cap;
        end
      end
      if (cmd.hash_step) begin
        hash_r <= hash_nxt;
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.finish) begin
        if (sts.more) begin
          pos_r <= pos_r + LEN_W'(1);
        end else begin
          pos_r      <= '0;
          rejected_r <= 1'b0;
          if (!rejected_r) begin
            energy_r <= energy_nxt;
            stored_r <= stored_r + cur_len_r;
          end
        end
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_root_hash    = out_hash_r;
  assign out_stored_total = out_stored_r;

endmodule

FILE: src/quantize_and_hash_ingest.sv
// Sequence: a hashed element passes the start, hash and element-end states before the
//   next accept; a rejected element skips hash, and a zero-length word goes to emit.
// The last element of a vector then waits in emit for a free output and registers its word.
// Throughput is set by the fold unit: three FNV-1a byte folds per cycle, 12 bytes per record.
// Reset: synchronous, active low; hash to the FNV basis, counts to zero,
//   energy to 180 units, capacity 12504 and budget 3100.
// ----------------------------------------------------------------------------
// quantize_and_hash_ingest
// Capacity-checked vector ingest folding quantized records into an FNV-1a hash.
// ----------------------------------------------------------------------------
module quantize_and_hash_ingest import qhi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample_bits,
  input  logic [LEN_W-1:0]    in_vector_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [HASH_W-1:0]   out_root_hash,
  output logic [LEN_W-1:0]    out_stored_total
);

  qhi_cmd_t cmd;
  qhi_sts_t sts;

  qhi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qhi_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_sample_bits   (in_sample_bits),
    .in_vector_length (in_vector_length),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_root_hash    (out_root_hash),
    .out_stored_total (out_stored_total),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

FILE: src/qhi_checker.sv
// ----------------------------------------------------------------------------
// qhi_checker
// Port-level checks for quantize_and_hash_ingest, bound to the top level.
// ----------------------------------------------------------------------------
`include "quantize_and_hash_ingest_defines.svh"

module qhi_checker import qhi_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          out_status,
  input logic [HASH_W-1:0]   out_root_hash,
  input logic [LEN_W-1:0]    out_stored_total
);

  `QHI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `QHI_ASSERT_NOW(a_status_code, out_valid, out_status <= STATUS_REJECT)
  `QHI_ASSERT_NOW(a_ingest_nonzero, out_valid && out_status != STATUS_REJECT,
                  out_stored_total != '0)
  `QHI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_root_hash) && $stable(out_stored_total))

endmodule

bind quantize_and_hash_ingest qhi_checker u_qhi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_root_hash    (out_root_hash),
  .out_stored_total (out_stored_total)
);

FILE: tb/tb_quantize_and_hash_ingest.sv
// ----------------------------------------------------------------------------
// tb_quantize_and_hash_ingest
// Self-checking bench for the vector ingest block: a directed table, then
// randomized vectors under varied idle/stall patterns, each result word
// checked field by field against an in-bench model of the hash and counters.
// ----------------------------------------------------------------------------
module tb_quantize_and_hash_ingest import qhi_pkg::*; ();

  localparam logic [HASH_W-1:0] HASH_PRIME = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] SCALE_FACTOR   = 64'd10000;
  localparam int          DENORM_EXP     = -149;
  localparam int          EXP_OFFSET     = 150;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          PHASE_WORDS    = 72;
  localparam int          PRESSURE_WORDS = 40;

  typedef struct packed {
    logic [1:0]        status;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  total;
  } ingest_result_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_CHECKED, ROW_CFG} row_kind_t;

  // cfg rows: bits carries the write data, len carries the register index
  typedef struct {
    row_kind_t            kind;
    logic [SAMPLE_W-1:0]  bits;
    logic [LEN_W-1:0]     len;
    ingest_result_t       want;
  } stim_row_t;

  localparam ingest_result_t NO_RESULT = '0;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample_bits = '0;
  logic [LEN_W-1:0]    in_vector_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [HASH_W-1:0]   out_root_hash;
  logic [LEN_W-1:0]    out_stored_total;

  quantize_and_hash_ingest DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_bits   (in_sample_bits),
    .in_vector_length (in_vector_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_root_hash    (out_root_hash),
    .out_stored_total (out_stored_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state and register copies
  logic [CAP_W-1:0]    model_cap;
  logic [BUDGET_W-1:0] model_budget;
  logic [LEN_W-1:0]    stored_cnt;
  logic [HASH_W-1:0]   chain_hash;
  logic [ENERGY_W-1:0] energy;
  logic [LEN_W-1:0]    vec_pos;
  logic [LEN_W-1:0]    vec_len;
  bit                  vec_dropped;

  ingest_result_t pending_results[$];
  ingest_result_t head;

  int error_count = 0;
  int words_in = 0;
  int results_seen = 0;
  int rejects_seen = 0;
  int over_budget_seen = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int phase_start;
  int send_idle_by_mode[4] = '{0, 53, 0, 22};
  int stall_by_mode[4] = '{0, 0, 53, 22};

  stim_row_t directed_rows[25] = '{
    '{ROW_CHECKED, 32'h0000_0000, 17'd0, '{STATUS_REJECT, FNV_BASIS, 17'd0}},
    '{ROW_WORD, 32'h0000_0000, 17'd1, NO_RESULT},
    '{ROW_WORD, 32'h8000_0000, 17'd3, NO_RESULT},
    '{ROW_WORD, 32'h7F80_0000, 17'h1FFFF, NO_RESULT},
    '{ROW_WORD, 32'hFF80_0001, 17'd0, NO_RESULT},
    '{ROW_WORD, 32'h0000_0001, 17'd2, NO_RESULT},
    '{ROW_WORD, 32'h007F_FFFF, 17'h0AAAA, NO_RESULT},
    '{ROW_WORD, 32'h7F7F_FFFF, 17'd2, NO_RESULT},
    '{ROW_WORD, 32'h3F80_0000, 17'h15555, NO_RESULT},
    '{ROW_WORD, 32'h48D1_B717, 17'd2, NO_RESULT},
    '{ROW_WORD, 32'hC8D1_B718, 17'd0, NO_RESULT},
    '{ROW_CFG, 32'd0, 17'(CFG_BUDGET), NO_RESULT},
    '{ROW_WORD, 32'h3DCC_CCCD, 17'd1, NO_RESULT},
    '{ROW_CFG, 32'hFFFF, 17'(CFG_BUDGET), NO_RESULT},
    '{ROW_WORD, 32'h5A5A_5A5A, 17'd1, NO_RESULT},
    '{ROW_CFG, 32'd1, 17'(CFG_CAPACITY), NO_RESULT},
    '{ROW_WORD, 32'hFFFF_FFFF, 17'd2, NO_RESULT},
    '{ROW_WORD, 32'h1234_5678, 17'd0, NO_RESULT},
    '{ROW_WORD, 32'hA5A5_A5A5, 17'd0, NO_RESULT},
    '{ROW_CFG, 32'd65536, 17'(CFG_CAPACITY), NO_RESULT},
    '{ROW_WORD, 32'h4B18_9680, 17'd1, NO_RESULT},
    '{ROW_CFG, 32'(CAP_RESET), 17'(CFG_CAPACITY), NO_RESULT},
    '{ROW_CFG, 32'(BUDGET_RESET), 17'(CFG_BUDGET), NO_RESULT},
    '{ROW_WORD, 32'h3A83_126F, 17'd1, NO_RESULT},
    '{ROW_WORD, 32'h0080_0000, 17'd1, NO_RESULT}
  };

  function automatic logic [HASH_W-1:0] fold_octet(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
    return (h ^ {56'd0, b}) * HASH_PRIME;
  endfunction

  function automatic logic [HASH_W-1:0] fold_le32(input logic [HASH_W-1:0] h,
                                                  input logic [31:0] w);
    logic [HASH_W-1:0] acc;
    acc = h;
    for (int k = 0; k < 4; k++) acc = fold_octet(acc, w[8*k +: 8]);
    return acc;
  endfunction

  // floor(|x| * 10000) with the product rounded to single precision first
  function automatic logic [31:0] scale_magnitude(input logic [30:0] mag);
    logic [7:0]  ex;
    logic [63:0] sig;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] r;
    int          exp2;
    int          width;
    int          sh;
    ex = mag[30:23];
    if (ex == EXP_SPECIAL) return '1;
    if (ex == 8'd0) begin
      sig = {41'd0, mag[22:0]};
      exp2 = DENORM_EXP;
    end else begin
      sig = {40'd0, 1'b1, mag[22:0]};
      exp2 = int'(ex) - EXP_OFFSET;
    end
    prod = sig * SCALE_FACTOR;
    if (prod == 64'd0) return '0;
    width = 0;
    while (width < 64 && (prod >> width) != 64'd0) width++;
    r = prod;
    if (width > 24) begin
      sh = width - 24;
      q = prod >> sh;
      rem = prod & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      r = q << sh;
    end
    if (exp2 >= 0) begin
      if (exp2 >= 32) return '1;
      if ((r >> (32 - exp2)) != 64'd0) return '1;
      return r[31:0] << exp2;
    end
    if (-exp2 >= 64) return '0;
    r = r >> (-exp2);
    if (r > 64'hFFFF_FFFF) return '1;
    return r[31:0];
  endfunction

  task automatic reset_model();
    model_cap = CAP_RESET;
    model_budget = BUDGET_RESET;
    stored_cnt = '0;
    chain_hash = FNV_BASIS;
    energy = ENERGY_RESET;
    vec_pos = '0;
    vec_len = '0;
    vec_dropped = 1'b0;
  endtask

  task automatic ingest_word(input logic [SAMPLE_W-1:0] bits, input logic [LEN_W-1:0] len,
                             output bit has_result, output ingest_result_t res);
    logic [30:0]       mag;
    logic [15:0]       idx;
    logic [HASH_W-1:0] h;
    logic [33:0]       esum;
    has_result = 1'b0;
    res = '0;
    if (vec_pos == '0) begin
      if (len == '0) begin
        has_result = 1'b1;
        res = '{STATUS_REJECT, chain_hash, stored_cnt};
        return;
      end
      vec_len = len;
      vec_dropped = (18'(stored_cnt) + 18'(len)) > 18'(model_cap);
    end
    if (!vec_dropped) begin
      mag = bits[30:0];
      idx = 16'(stored_cnt + vec_pos);
      h = fold_octet(chain_hash, idx[7:0]);
      h = fold_octet(h, idx[15:8]);
      h = fold_octet(h, 8'd0);
      h = fold_octet(h, 8'd0);
      h = fold_le32(h, {1'b0, mag});
      chain_hash = fold_le32(h, scale_magnitude(mag));
    end
    vec_pos = vec_pos + LEN_W'(1);
    if (vec_pos < vec_len) return;
    vec_pos = '0;
    has_result = 1'b1;
    if (vec_dropped) begin
      res.status = STATUS_REJECT;
    end else begin
      esum = 34'(energy) + 34'(vec_len) * 34'd2;
      energy = (esum > 34'hFFFF_FFFF) ? '1 : esum[31:0];
      stored_cnt = stored_cnt + vec_len;
      res.status = (energy <= 32'(model_budget)) ? STATUS_OK : STATUS_OVER_BUDGET;
    end
    vec_dropped = 1'b0;
    res.hash = chain_hash;
    res.total = stored_cnt;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic drive_word(input logic [SAMPLE_W-1:0] bits, input logic [LEN_W-1:0] len,
                            input bit typed, input ingest_result_t want);
    bit             has_result;
    ingest_result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_bits <= bits;
    in_vector_length <= len;
    do @(posedge clk); while (in_stall);
    words_in++;
    ingest_word(bits, len, has_result, res);
    if (has_result) pending_results.push_back(typed ? want : res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) model_cap = val;
    else model_budget = val[BUDGET_W-1:0];
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w[30:23] = EXP_SPECIAL;
      1: w[30:23] = 8'd0;
      2: w[30:23] = 8'(135 + $urandom_range(0, 20));
      3: w[30:23] = 8'(105 + $urandom_range(0, 30));
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_random_vector(input int max_len);
    int pick;
    int len;
    int count;
    pick = $urandom_range(0, 99);
    if (pick < 6) len = 0;
    else if (pick < 80) len = $urandom_range(1, (max_len < 6) ? max_len : 6);
    else if (pick < 97) len = $urandom_range(1, (max_len < 40) ? max_len : 40);
    else len = $urandom_range(1, max_len);
    count = (len == 0) ? 1 : len;
    for (int i = 0; i < count; i++)
      drive_word(random_sample(), (i == 0) ? LEN_W'(len) : LEN_W'($urandom), 1'b0, NO_RESULT);
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", out_root_hash, '0);
      end else begin
        head = pending_results.pop_front();
        results_seen++;
        if (head.status == STATUS_REJECT) rejects_seen++;
        if (head.status == STATUS_OVER_BUDGET) over_budget_seen++;
        if (out_status !== head.status)
          report_mismatch("status", 64'(out_status), 64'(head.status));
        if (out_root_hash !== head.hash)
          report_mismatch("root_hash", out_root_hash, head.hash);
        if (out_stored_total !== head.total)
          report_mismatch("stored_total", 64'(out_stored_total), 64'(head.total));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles, %0d words pending", $time,
               quiet_cycles, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed_rows[i].len[0], directed_rows[i].bits[CFG_W-1:0]);
      end else begin
        drive_word(directed_rows[i].bits, directed_rows[i].len,
                   directed_rows[i].kind == ROW_CHECKED, directed_rows[i].want);
      end
    end
    drain_results();

    for (int p = 0; p < 8; p++) begin
      send_idle_pct = send_idle_by_mode[p % 4];
      recv_stall_pct = stall_by_mode[p % 4];
      case (p)
        1: write_reg(CFG_CAPACITY, 17'h10000);
        3: write_reg(CFG_CAPACITY, 17'd1);
        6: write_reg(CFG_CAPACITY, CAP_RESET);
        default: write_reg(CFG_CAPACITY,
                           CFG_W'(stored_cnt + LEN_W'($urandom_range(10, 150))));
      endcase
      case (p)
        2: write_reg(CFG_BUDGET, 17'd0);
        5: write_reg(CFG_BUDGET, 17'hFFFF);
        7: write_reg(CFG_BUDGET, CFG_W'(BUDGET_RESET));
        default: write_reg(CFG_BUDGET,
                           CFG_W'((energy + $urandom_range(0, 120)) & 32'hFFFF));
      endcase
      phase_start = words_in;
      while (words_in - phase_start < PHASE_WORDS) begin
        send_random_vector(160);
        if ($urandom_range(0, 14) == 0) drain_results();
      end
      drain_results();
    end

    // hold off the output so results back up into the input
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    phase_start = words_in;
    while (words_in - phase_start < PRESSURE_WORDS) send_random_vector(2);
    drain_results();

    $display("Covered %0d input words and %0d result words (%0d rejected, %0d over budget)",
             words_in, results_seen, rejects_seen, over_budget_seen);
    $display("over a directed table, eight idle/stall phases and one long output hold.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/qhi_pkg.sv
src/qhi_ctrl.sv
src/qhi_datapath.sv
src/quantize_and_hash_ingest.sv
src/qhi_checker.sv
tb/tb_quantize_and_hash_ingest.sv
